@@ hdl/kwt_pkg.sv @@
//------------------------------------------------------------------------------
// kwt_pkg
// Shared types, constants and the keyword table for the keyword tokenizer.
//------------------------------------------------------------------------------
`default_nettype none

package kwt_pkg;

   typedef enum logic [2:0] {
      MODE_IDLE  = 3'd0,
      MODE_NUM   = 3'd1,
      MODE_IDENT = 3'd2,
      MODE_STR   = 3'd3,
      MODE_ESC   = 3'd4,
      MODE_OP2   = 3'd5,
      MODE_DASH  = 3'd6,
      MODE_DROP  = 3'd7
   } mode_type;

   localparam int unsigned NUM_KW   = 22;
   localparam int unsigned KW_CHARS = 10;

   localparam logic [5:0] CLS_IDENT  = 6'd0;
   localparam logic [5:0] CLS_NUMBER = 6'd1;
   localparam logic [5:0] CLS_STRING = 6'd2;
   localparam logic [5:0] CLS_BINOP  = 6'd3;
   localparam logic [5:0] CLS_LPAREN = 6'd4;
   localparam logic [5:0] CLS_RPAREN = 6'd5;
   localparam logic [5:0] CLS_LBRACE = 6'd6;
   localparam logic [5:0] CLS_RBRACE = 6'd7;
   localparam logic [5:0] CLS_LBRACK = 6'd8;
   localparam logic [5:0] CLS_RBRACK = 6'd9;
   localparam logic [5:0] CLS_EQUAL  = 6'd10;
   localparam logic [5:0] CLS_COMMA  = 6'd11;
   localparam logic [5:0] CLS_KW0    = 6'd12;
   localparam logic [5:0] CLS_EOF    = 6'd34;
   localparam logic [5:0] CLS_ERROR  = 6'd35;
   localparam logic [5:0] CLS_NONE   = 6'd63;

   typedef struct packed {
      logic [7:0] chr;
      logic       first;
      logic       last;
      logic [5:0] cls;
   } tok_type;

   typedef struct packed {
      logic       count2;
      tok_type    r0;
      tok_type    r1;
   } rsp_pair_type;

   function automatic logic [7:0] kw_char(input logic [4:0] k, input logic [3:0] p);
      logic [8*KW_CHARS-1:0] s;
      unique case (k)
         5'd0:  s = {"variable", 16'h0};
         5'd1:  s = {"func", 48'h0};
         5'd2:  s = {"true", 48'h0};
         5'd3:  s = {"false", 40'h0};
         5'd4:  s = {"call", 48'h0};
         5'd5:  s = {"if", 64'h0};
         5'd6:  s = {"elseif", 32'h0};
         5'd7:  s = {"else", 48'h0};
         5'd8:  s = {"while", 40'h0};
         5'd9:  s = {"for", 56'h0};
         5'd10: s = {"class", 40'h0};
         5'd11: s = {"throw", 40'h0};
         5'd12: s = {"catch", 40'h0};
         5'd13: s = {"try", 56'h0};
         5'd14: s = {"reinit", 32'h0};
         5'd15: s = {"return", 32'h0};
         5'd16: s = {"break", 40'h0};
         5'd17: s = {"continue", 16'h0};
         5'd18: s = {"lambda", 32'h0};
         5'd19: s = {"idx", 56'h0};
         5'd20: s = {"idx", "_", "reinit"};
         5'd21: s = {"struct", 32'h0};
         default: s = '0;
      endcase
      if (p < 4'(KW_CHARS)) begin
         kw_char = s[8*KW_CHARS-1 - 8*p -: 8];
      end else begin
         kw_char = 8'h00;
      end
   endfunction

   function automatic logic [3:0] kw_len(input logic [4:0] k);
      unique case (k)
         5'd0: kw_len = 4'd8;   5'd1: kw_len = 4'd4;   5'd2: kw_len = 4'd4;
         5'd3: kw_len = 4'd5;   5'd4: kw_len = 4'd4;   5'd5: kw_len = 4'd2;
         5'd6: kw_len = 4'd6;   5'd7: kw_len = 4'd4;   5'd8: kw_len = 4'd5;
         5'd9: kw_len = 4'd3;   5'd10: kw_len = 4'd5;  5'd11: kw_len = 4'd5;
         5'd12: kw_len = 4'd5;  5'd13: kw_len = 4'd3;  5'd14: kw_len = 4'd6;
         5'd15: kw_len = 4'd6;  5'd16: kw_len = 4'd5;  5'd17: kw_len = 4'd8;
         5'd18: kw_len = 4'd6;  5'd19: kw_len = 4'd3;  5'd20: kw_len = 4'd10;
         5'd21: kw_len = 4'd6;
         default: kw_len = 4'd0;
      endcase
   endfunction

   function automatic logic is_dig(input logic [7:0] c);
      is_dig = (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alf(input logic [7:0] c);
      logic [7:0] l;
      l = c | 8'h20;
      is_alf = (l >= "a") && (l <= "z");
   endfunction

   function automatic logic is_idc(input logic [7:0] c);
      is_idc = is_alf(c) || is_dig(c) || (c == "_");
   endfunction

   function automatic logic [5:0] punct_class(input logic [7:0] c);
      unique case (c)
         "(": punct_class = CLS_LPAREN;
         ")": punct_class = CLS_RPAREN;
         "{": punct_class = CLS_LBRACE;
         "}": punct_class = CLS_RBRACE;
         "[": punct_class = CLS_LBRACK;
         "]": punct_class = CLS_RBRACK;
         "=": punct_class = CLS_EQUAL;
         ",": punct_class = CLS_COMMA;
         "+", "-", "*", "/", "%", ">", "<": punct_class = CLS_BINOP;
         default: punct_class = CLS_NONE;
      endcase
   endfunction

endpackage

`default_nettype wire

@@ hdl/kwt_lexer.sv @@
//------------------------------------------------------------------------------
// kwt_lexer
// Lexer state and single-pass classification of the held byte with lookahead.
//------------------------------------------------------------------------------
`default_nettype none

module kwt_lexer (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire logic [7:0]            in_char,
   input  wire logic                  in_end,
   output kwt_pkg::rsp_pair_type      pair,
   output logic                       pair_count_nz
);

   logic [7:0]         held_byte_ff, held_byte_in;
   logic               held_valid_ff, held_valid_in;
   kwt_pkg::mode_type  mode_ff, mode_in;
   logic [21:0]        kw_ff, kw_in;
   logic [3:0]         len_ff, len_in;

   logic [21:0]        kw_fed;
   logic [3:0]         len_fed;
   logic [5:0]         kw_cls;
   logic [1:0]         n;
   kwt_pkg::tok_type   r0, r1;

   // Keyword match after feeding the held byte.
   always_comb begin
      logic [21:0] base;
      base = (mode_ff == kwt_pkg::MODE_IDENT) ? kw_ff : '1;
      len_fed = (mode_ff == kwt_pkg::MODE_IDENT) ? len_ff : 4'd0;
      for (int k = 0; k < kwt_pkg::NUM_KW; k++) begin
         kw_fed[k] = base[k] && (len_fed < kwt_pkg::kw_len(5'(k)))
                     && (kwt_pkg::kw_char(5'(k), len_fed) == held_byte_ff);
      end
      if (len_fed != 4'd15) begin
         len_fed = len_fed + 4'd1;
      end
      kw_cls = kwt_pkg::CLS_IDENT;
      for (int k = kwt_pkg::NUM_KW - 1; k >= 0; k--) begin
         if (kw_fed[k] && (kwt_pkg::kw_len(5'(k)) == len_fed)) begin
            kw_cls = kwt_pkg::CLS_KW0 + 6'(k);
         end
      end
   end

   function automatic kwt_pkg::tok_type mk(input logic [7:0] c, input logic f,
                                           input logic l, input logic [5:0] cl);
      kwt_pkg::tok_type t;
      t.chr = c; t.first = f; t.last = l; t.cls = cl;
      mk = t;
   endfunction

   always_comb begin
      logic [7:0] c, b, d;
      logic       eoi, run, err;
      c = held_byte_ff;
      eoi = in_end;
      b = eoi ? 8'h00 : in_char;
      d = 8'h30 + {4'd0, len_ff};
      n = 2'd0;
      r0 = mk(8'h00, 1'b0, 1'b0, 6'd0);
      r1 = mk(8'h00, 1'b1, 1'b1, kwt_pkg::CLS_EOF);
      mode_in = mode_ff;
      kw_in = kw_ff;
      len_in = len_ff;
      held_byte_in = held_byte_ff;
      held_valid_in = held_valid_ff;
      err = 1'b0;
      run = held_valid_ff && (mode_ff != kwt_pkg::MODE_DROP)
            && (eoi || !(mode_ff == kwt_pkg::MODE_DROP));
      if (run) begin
         unique case (mode_ff)
            kwt_pkg::MODE_IDLE: begin
               if (c == " " || c == 8'h09 || c == 8'h0a || c == 8'h0d) begin
               end else if (c == 8'h00) begin
                  mode_in = kwt_pkg::MODE_DROP;
               end else if (kwt_pkg::is_dig(c)) begin
                  if (kwt_pkg::is_dig(b)) begin
                     n = 2'd1; r0 = mk(c, 1'b1, 1'b0, 6'd0);
                     mode_in = kwt_pkg::MODE_NUM;
                  end else if (b == "-") begin
                     len_in = c[3:0] - 4'h0; kw_in = 22'd1;
                     mode_in = kwt_pkg::MODE_DASH;
                  end else begin
                     n = 2'd1; r0 = mk(c, 1'b1, 1'b1, kwt_pkg::CLS_NUMBER);
                     mode_in = kwt_pkg::MODE_IDLE;
                  end
               end else if (c == "-" && kwt_pkg::is_dig(b)) begin
                  n = 2'd1; r0 = mk(c, 1'b1, 1'b0, 6'd0);
                  mode_in = kwt_pkg::MODE_NUM;
               end else if (kwt_pkg::is_alf(c)) begin
                  kw_in = kw_fed; len_in = len_fed; n = 2'd1;
                  if (kwt_pkg::is_idc(b)) begin
                     r0 = mk(c, 1'b1, 1'b0, 6'd0); mode_in = kwt_pkg::MODE_IDENT;
                  end else begin
                     r0 = mk(c, 1'b1, 1'b1, kw_cls); mode_in = kwt_pkg::MODE_IDLE;
                  end
               end else if (c == "=" && (b == "=" || b == ">" || b == "<" || b == "!")) begin
                  n = 2'd1; r0 = mk(c, 1'b1, 1'b0, 6'd0);
                  mode_in = kwt_pkg::MODE_OP2;
               end else if (c == 8'h22) begin
                  if (eoi) begin
                     err = 1'b1;
                  end else begin
                     len_in = 4'd0;
                     if (b == 8'h22) begin
                        n = 2'd1; r0 = mk(8'h00, 1'b1, 1'b1, kwt_pkg::CLS_STRING);
                        len_in = 4'd1;
                     end
                     mode_in = kwt_pkg::MODE_STR;
                  end
               end else if (kwt_pkg::punct_class(c) != kwt_pkg::CLS_NONE) begin
                  n = 2'd1; r0 = mk(c, 1'b1, 1'b1, kwt_pkg::punct_class(c));
               end else begin
                  err = 1'b1;
               end
            end
            kwt_pkg::MODE_NUM: begin
               if (kwt_pkg::is_dig(b)) begin
                  n = 2'd1; r0 = mk(c, 1'b0, 1'b0, 6'd0);
               end else if (b == "-") begin
                  len_in = c[3:0] - 4'h0; kw_in = 22'd0;
                  mode_in = kwt_pkg::MODE_DASH;
               end else begin
                  n = 2'd1; r0 = mk(c, 1'b0, 1'b1, kwt_pkg::CLS_NUMBER);
                  mode_in = kwt_pkg::MODE_IDLE;
               end
            end
            kwt_pkg::MODE_IDENT: begin
               kw_in = kw_fed; len_in = len_fed; n = 2'd1;
               if (kwt_pkg::is_idc(b)) begin
                  r0 = mk(c, 1'b0, 1'b0, 6'd0);
               end else begin
                  r0 = mk(c, 1'b0, 1'b1, kw_cls); mode_in = kwt_pkg::MODE_IDLE;
               end
            end
            kwt_pkg::MODE_STR, kwt_pkg::MODE_ESC: begin
               if (mode_ff == kwt_pkg::MODE_STR && c == 8'h22) begin
                  mode_in = kwt_pkg::MODE_IDLE;
               end else if (eoi || (mode_ff == kwt_pkg::MODE_STR && c == 8'h00)) begin
                  err = 1'b1;
               end else if (mode_ff == kwt_pkg::MODE_STR && c == 8'h5c && b == "n") begin
                  mode_in = kwt_pkg::MODE_ESC;
               end else begin
                  n = 2'd1;
                  r0 = mk((mode_ff == kwt_pkg::MODE_ESC) ? 8'h0a : c, len_ff == 4'd0,
                          b == 8'h22, (b == 8'h22) ? kwt_pkg::CLS_STRING : 6'd0);
                  len_in = 4'd1;
                  mode_in = kwt_pkg::MODE_STR;
               end
            end
            kwt_pkg::MODE_OP2: begin
               n = 2'd1; r0 = mk(c, 1'b0, 1'b1, kwt_pkg::CLS_BINOP);
               mode_in = kwt_pkg::MODE_IDLE;
            end
            kwt_pkg::MODE_DASH: begin
               n = 2'd1; mode_in = kwt_pkg::MODE_IDLE;
               if (eoi) begin
                  r0 = mk(d, kw_ff[0], 1'b1, kwt_pkg::CLS_NUMBER);
               end else if (kwt_pkg::is_dig(b)) begin
                  n = 2'd2; r0 = mk(d, kw_ff[0], 1'b0, 6'd0);
                  r1 = mk(c, 1'b0, 1'b0, 6'd0); mode_in = kwt_pkg::MODE_NUM;
               end else begin
                  n = 2'd2; r0 = mk(d, kw_ff[0], 1'b1, kwt_pkg::CLS_NUMBER);
                  r1 = mk(c, 1'b1, 1'b1, kwt_pkg::CLS_BINOP);
               end
            end
            default: begin
            end
         endcase
         if (err) begin
            n = 2'd1; r0 = mk(8'h00, 1'b1, 1'b1, kwt_pkg::CLS_ERROR);
            mode_in = kwt_pkg::MODE_DROP;
         end
      end
      if (eoi) begin
         // At end of input only one result of the flush survives, then eof.
         if (n == 2'd0) begin
            r0 = mk(8'h00, 1'b1, 1'b1, kwt_pkg::CLS_EOF);
            n = 2'd1;
         end else begin
            r1 = mk(8'h00, 1'b1, 1'b1, kwt_pkg::CLS_EOF);
            n = 2'd2;
         end
         held_byte_in = 8'h00; held_valid_in = 1'b0;
         mode_in = kwt_pkg::MODE_IDLE; kw_in = '1; len_in = 4'd0;
      end else if (mode_ff == kwt_pkg::MODE_DROP) begin
         n = 2'd0;
         mode_in = mode_ff; kw_in = kw_ff; len_in = len_ff;
      end else if (!held_valid_ff) begin
         held_byte_in = in_char; held_valid_in = 1'b1;
      end else begin
         held_byte_in = in_char;
         if (mode_in == kwt_pkg::MODE_DROP) begin
            held_valid_in = 1'b0;
         end
      end
   end

   always_comb begin
      pair.count2 = n[1];
      pair.r0 = r0;
      pair.r1 = r1;
      pair_count_nz = (n != 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_byte_ff <= 8'h00;
         held_valid_ff <= 1'b0;
         mode_ff <= kwt_pkg::MODE_IDLE;
         kw_ff <= '1;
         len_ff <= 4'd0;
      end else if (step) begin
         held_byte_ff <= held_byte_in;
         held_valid_ff <= held_valid_in;
         mode_ff <= mode_in;
         kw_ff <= kw_in;
         len_ff <= len_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/kwt_outbuf.sv @@
//------------------------------------------------------------------------------
// kwt_outbuf
// Result buffer holding up to two pending result beats from one input beat.
//------------------------------------------------------------------------------
`default_nettype none

module kwt_outbuf (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  wire logic                  load_nz,
   input  kwt_pkg::rsp_pair_type      pair,
   output logic                       can_load,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output kwt_pkg::tok_type           head
);

   kwt_pkg::tok_type  slot0_ff, slot0_in, slot1_ff, slot1_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              pop;

   assign rsp_valid = (cnt_ff != 2'd0);
   assign head = slot0_ff;
   assign pop = rsp_valid && rsp_ready;
   // A new pair may enter when the buffer is empty or drains this cycle.
   assign can_load = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && rsp_ready);

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      cnt_in = cnt_ff;
      if (pop) begin
         slot0_in = slot1_ff;
         cnt_in = cnt_ff - 2'd1;
      end
      if (load && load_nz) begin
         slot0_in = pair.r0;
         slot1_in = pair.r1;
         cnt_in = pair.count2 ? 2'd2 : 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/keyword_tokenizer.sv @@
//------------------------------------------------------------------------------
// keyword_tokenizer
// Streaming lexer with one byte of lookahead and a 22-entry keyword matcher.
//------------------------------------------------------------------------------
// Usage: source bytes enter on the req_ channel (req_in_end marks end of text,
// with no byte). Each accepted beat is classified in one pass against the byte
// held from the previous beat, and yields zero, one or two result beats on the
// rsp_ channel: one token byte per beat, first/last marks, class on last.
// Results of a request beat are shown the cycle after it is accepted.
// Throughput: one request beat per cycle while each yields at most one result
// and the receiver takes one per cycle; a beat yielding two results (a number
// followed by a minus, or a flush at end of input) holds off the next request
// beat while the single result port drains the two-entry result buffer.
// Reset clears the held byte, the mode and the keyword match; the result
// buffer comes up empty. When the receiver stalls, results wait in the
// buffer and req_ready drops once it cannot take another pair.
//------------------------------------------------------------------------------
`default_nettype none

module keyword_tokenizer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_in_char,
   input  wire logic        req_in_end,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_char,
   output logic             rsp_token_first,
   output logic             rsp_token_last,
   output logic [5:0]       rsp_token_class
);

   kwt_pkg::rsp_pair_type pair;
   kwt_pkg::tok_type      head;
   logic                  pair_nz;
   logic                  step;

   assign step = req_valid && req_ready;

   kwt_lexer u_lexer (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .in_char       (req_in_char),
      .in_end        (req_in_end),
      .pair          (pair),
      .pair_count_nz (pair_nz)
   );

   kwt_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .load      (step),
      .load_nz   (pair_nz),
      .pair      (pair),
      .can_load  (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .head      (head)
   );

   assign rsp_out_char = head.chr;
   assign rsp_token_first = head.first;
   assign rsp_token_last = head.last;
   assign rsp_token_class = head.cls;

   a_class_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_token_last |-> rsp_token_class == 6'd0)
      else $error("class set on a beat that is not last");

   a_eof_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_class == kwt_pkg::CLS_EOF |-> rsp_token_first
         && rsp_token_last && rsp_out_char == 8'h00)
      else $error("malformed end-of-file beat");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid
         && $stable({rsp_out_char, rsp_token_first, rsp_token_last, rsp_token_class}))
      else $error("result beat changed while stalled");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with an empty result buffer");

endmodule

`default_nettype wire

@@ sim/kwt_checker.sv @@
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// kwt_checker
// Watches both channels of the keyword tokenizer. It predicts every token
// byte from the accepted source beats and compares each result beat in order.
//------------------------------------------------------------------------------
module kwt_checker (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_ready,
   input  wire logic [7:0] req_in_char,
   input  wire logic       req_in_end,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire logic [7:0] rsp_out_char,
   input  wire logic       rsp_token_first,
   input  wire logic       rsp_token_last,
   input  wire logic [5:0] rsp_token_class,
   output int              fail_count,
   output int              pending_tokens,
   output int              token_beats
);

   string keywords [kwt_pkg::NUM_KW] = '{
      "variable", "func", "true", "false", "call", "if", "elseif", "else",
      "while", "for", "class", "throw", "catch", "try", "reinit", "return",
      "break", "continue", "lambda", "idx", "", "struct"
   };

   kwt_pkg::tok_type  token_queue [$];
   logic [7:0]        held_char;
   logic              held_live;
   kwt_pkg::mode_type mode;
   logic [21:0]       kw_alive;
   logic [3:0]        word_len;
   int                beat_results;

   // The longest keyword is built from two shorter ones.
   initial keywords[20] = {keywords[19], "_", keywords[14]};

   function automatic logic digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic letter(input logic [7:0] c);
      logic [7:0] l;
      l = c | 8'h20;
      return l >= "a" && l <= "z";
   endfunction

   function automatic logic [5:0] mark_class(input logic [7:0] c);
      case (c)
         "(": return kwt_pkg::CLS_LPAREN;
         ")": return kwt_pkg::CLS_RPAREN;
         "{": return kwt_pkg::CLS_LBRACE;
         "}": return kwt_pkg::CLS_RBRACE;
         "[": return kwt_pkg::CLS_LBRACK;
         "]": return kwt_pkg::CLS_RBRACK;
         "=": return kwt_pkg::CLS_EQUAL;
         ",": return kwt_pkg::CLS_COMMA;
         "+", "-", "*", "/", "%", ">", "<": return kwt_pkg::CLS_BINOP;
         default: return kwt_pkg::CLS_NONE;
      endcase
   endfunction

   task automatic put_token(input logic [7:0] c, input logic f, input logic l,
                            input logic [5:0] cl);
      kwt_pkg::tok_type t;
      if (beat_results < 2) begin
         t.chr = c; t.first = f; t.last = l; t.cls = cl;
         token_queue.insert(token_queue.size(), t);
         beat_results++;
      end
   endtask

   task automatic clear_state();
      held_char = 8'h00;
      held_live = 1'b0;
      mode = kwt_pkg::MODE_IDLE;
      kw_alive = '1;
      word_len = 4'd0;
   endtask

   task automatic flag_error();
      put_token(8'h00, 1'b1, 1'b1, kwt_pkg::CLS_ERROR);
      mode = kwt_pkg::MODE_DROP;
   endtask

   task automatic number_char(input logic [7:0] c, input logic [7:0] b, input logic f);
      if (digit(b)) begin
         put_token(c, f, 1'b0, kwt_pkg::CLS_IDENT);
         mode = kwt_pkg::MODE_NUM;
      end else if (b == "-") begin
         // The digit waits for the byte after the minus; its value and its
         // first mark are parked in the word length and match registers.
         word_len = 4'(c - "0");
         kw_alive = {21'b0, f};
         mode = kwt_pkg::MODE_DASH;
      end else begin
         put_token(c, f, 1'b1, kwt_pkg::CLS_NUMBER);
         mode = kwt_pkg::MODE_IDLE;
      end
   endtask

   task automatic word_char(input logic [7:0] c, input logic [7:0] b, input logic f);
      logic [5:0] cl;
      for (int k = 0; k < kwt_pkg::NUM_KW; k++)
         if (word_len >= keywords[k].len() || keywords[k][word_len] != c)
            kw_alive[k] = 1'b0;
      if (word_len < 15) word_len++;
      if (letter(b) || digit(b) || b == "_") begin
         put_token(c, f, 1'b0, kwt_pkg::CLS_IDENT);
         mode = kwt_pkg::MODE_IDENT;
      end else begin
         cl = kwt_pkg::CLS_IDENT;
         for (int k = kwt_pkg::NUM_KW - 1; k >= 0; k--)
            if (kw_alive[k] && keywords[k].len() == word_len)
               cl = kwt_pkg::CLS_KW0 + 6'(k);
         put_token(c, f, 1'b1, cl);
         mode = kwt_pkg::MODE_IDLE;
      end
   endtask

   task automatic quoted_char(input logic [7:0] v, input logic [7:0] b);
      logic l;
      l = (b == 8'h22);
      put_token(v, word_len == 0, l, l ? kwt_pkg::CLS_STRING : kwt_pkg::CLS_IDENT);
      word_len = 4'd1;
      mode = kwt_pkg::MODE_STR;
   endtask

   task automatic lex_char(input logic [7:0] c, input logic [7:0] b, input logic eoi);
      logic [7:0] d;
      logic [5:0] cl;
      case (mode)
         kwt_pkg::MODE_IDLE: begin
            if (c == " " || c == 8'h09 || c == 8'h0a || c == 8'h0d) begin
            end else if (c == 8'h00) begin
               mode = kwt_pkg::MODE_DROP;
            end else if (digit(c)) begin
               number_char(c, b, 1'b1);
            end else if (c == "-" && digit(b)) begin
               put_token(c, 1'b1, 1'b0, kwt_pkg::CLS_IDENT);
               mode = kwt_pkg::MODE_NUM;
            end else if (letter(c)) begin
               kw_alive = '1;
               word_len = 4'd0;
               word_char(c, b, 1'b1);
            end else if (c == "=" && (b == "=" || b == ">" || b == "<" || b == "!")) begin
               put_token(c, 1'b1, 1'b0, kwt_pkg::CLS_IDENT);
               mode = kwt_pkg::MODE_OP2;
            end else if (c == 8'h22) begin
               if (eoi) begin
                  flag_error();
               end else begin
                  word_len = 4'd0;
                  if (b == 8'h22) begin
                     put_token(8'h00, 1'b1, 1'b1, kwt_pkg::CLS_STRING);
                     word_len = 4'd1;
                  end
                  mode = kwt_pkg::MODE_STR;
               end
            end else begin
               cl = mark_class(c);
               if (cl != kwt_pkg::CLS_NONE) put_token(c, 1'b1, 1'b1, cl);
               else flag_error();
            end
         end
         kwt_pkg::MODE_NUM:   number_char(c, b, 1'b0);
         kwt_pkg::MODE_IDENT: word_char(c, b, 1'b0);
         kwt_pkg::MODE_STR: begin
            if (c == 8'h22) mode = kwt_pkg::MODE_IDLE;
            else if (eoi || c == 8'h00) flag_error();
            else if (c == 8'h5c && b == "n") mode = kwt_pkg::MODE_ESC;
            else quoted_char(c, b);
         end
         kwt_pkg::MODE_ESC: begin
            if (eoi) flag_error();
            else quoted_char(8'h0a, b);
         end
         kwt_pkg::MODE_OP2: begin
            put_token(c, 1'b0, 1'b1, kwt_pkg::CLS_BINOP);
            mode = kwt_pkg::MODE_IDLE;
         end
         kwt_pkg::MODE_DASH: begin
            d = "0" + {4'h0, word_len};
            if (eoi) begin
               put_token(d, kw_alive[0], 1'b1, kwt_pkg::CLS_NUMBER);
               mode = kwt_pkg::MODE_IDLE;
            end else if (digit(b)) begin
               put_token(d, kw_alive[0], 1'b0, kwt_pkg::CLS_IDENT);
               put_token(c, 1'b0, 1'b0, kwt_pkg::CLS_IDENT);
               mode = kwt_pkg::MODE_NUM;
            end else begin
               put_token(d, kw_alive[0], 1'b1, kwt_pkg::CLS_NUMBER);
               put_token(c, 1'b1, 1'b1, kwt_pkg::CLS_BINOP);
               mode = kwt_pkg::MODE_IDLE;
            end
         end
         default: ;
      endcase
   endtask

   task automatic predict_tokens(input logic [7:0] c, input logic eoi);
      beat_results = 0;
      if (eoi) begin
         if (held_live && mode != kwt_pkg::MODE_DROP) lex_char(held_char, 8'h00, 1'b1);
         // Only one flushed byte fits beside the end-of-file token.
         if (beat_results > 1) begin
            void'(token_queue.pop_back());
            beat_results = 1;
         end
         put_token(8'h00, 1'b1, 1'b1, kwt_pkg::CLS_EOF);
         clear_state();
      end else if (mode != kwt_pkg::MODE_DROP) begin
         if (!held_live) begin
            held_char = c;
            held_live = 1'b1;
         end else begin
            lex_char(held_char, c, 1'b0);
            held_char = c;
            if (mode == kwt_pkg::MODE_DROP) held_live = 1'b0;
         end
      end
   endtask

   task automatic check_token();
      kwt_pkg::tok_type want;
      if (token_queue.size() == 0) begin
         $display("%0t: unexpected result beat char %h first %b last %b class %0d",
                  $time, rsp_out_char, rsp_token_first, rsp_token_last, rsp_token_class);
         fail_count++;
      end else begin
         want = token_queue.pop_front();
         if (want.chr != rsp_out_char) begin
            $display("%0t: char expected %h actual %h", $time, want.chr, rsp_out_char);
            fail_count++;
         end
         if (want.first != rsp_token_first) begin
            $display("%0t: first expected %b actual %b", $time, want.first, rsp_token_first);
            fail_count++;
         end
         if (want.last != rsp_token_last) begin
            $display("%0t: last expected %b actual %b", $time, want.last, rsp_token_last);
            fail_count++;
         end
         if (want.cls != rsp_token_class) begin
            $display("%0t: class expected %0d actual %0d", $time, want.cls,
                     rsp_token_class);
            fail_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_state();
         token_queue.delete();
         fail_count = 0;
         token_beats = 0;
      end else begin
         if (req_valid && req_ready) predict_tokens(req_in_char, req_in_end);
         if (rsp_valid && rsp_ready) begin
            check_token();
            token_beats++;
         end
      end
      pending_tokens = token_queue.size();
   end

endmodule

@@ sim/tb_keyword_tokenizer.sv @@
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb_keyword_tokenizer
// Feeds the tokenizer directed and random source text, made mostly of legal
// tokens with some noise, under random stalls and one long receiver hold.
//------------------------------------------------------------------------------
module tb_keyword_tokenizer;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_BYTES = 950;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_in_char;
   logic       req_in_end;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_out_char;
   logic       rsp_token_first;
   logic       rsp_token_last;
   logic [5:0] rsp_token_class;
   int         fail_count;
   int         pending_tokens;
   int         token_beats;

   logic [8:0] source [$];   // {end flag, byte}
   int         sent;
   logic       quiet;
   int         hold_left;
   logic       long_hold_done;
   int         cycles;

   string keywords [kwt_pkg::NUM_KW] = '{
      "variable", "func", "true", "false", "call", "if", "elseif", "else",
      "while", "for", "class", "throw", "catch", "try", "reinit", "return",
      "break", "continue", "lambda", "idx", "", "struct"
   };

   keyword_tokenizer i_dut (.*);

   kwt_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic add_byte(input logic [8:0] v);
      source.insert(source.size(), v);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_byte({1'b0, s[i]});
   endtask

   task automatic add_end();
      add_byte({1'b1, 8'($urandom_range(0, 255))});
   endtask

   task automatic add_random_token();
      string punct = "(){}[]=,+-*/%><";
      int n;
      case ($urandom_range(0, 9))
         0: add_text(keywords[$urandom_range(0, kwt_pkg::NUM_KW - 1)]);
         1: begin
            add_byte({1'b0, 8'($urandom_range(0, 1) ? "a" : "Z") +
                      8'($urandom_range(0, 25))});
            n = $urandom_range(0, 12);
            repeat (n) add_text($urandom_range(0, 3) == 0 ? "_" :
                                $urandom_range(0, 1) ? "9" : "e");
         end
         2: begin
            if ($urandom_range(0, 2) == 0) add_text("-");
            n = $urandom_range(1, 5);
            repeat (n) begin
               add_byte({1'b0, 8'("0" + $urandom_range(0, 9))});
               if ($urandom_range(0, 3) == 0) add_text("-");
            end
         end
         3: begin
            add_text("\"");
            n = $urandom_range(0, 6);
            repeat (n) begin
               if ($urandom_range(0, 3) == 0) add_text("\\n");
               else add_byte({1'b0, 8'($urandom_range(32, 126))});
            end
            if ($urandom_range(0, 7) != 0) add_text("\"");
         end
         4: begin
            add_text("=");
            add_text($urandom_range(0, 3) == 0 ? "=" : $urandom_range(0, 1) ? ">" : "!");
         end
         5, 6: add_byte({1'b0, punct[$urandom_range(0, punct.len() - 1)]});
         7: add_text($urandom_range(0, 1) ? " " : "\t\n\r");
         8: begin
            if ($urandom_range(0, 5) == 0)
               add_byte({1'b0, 8'($urandom_range(0, 255))});
            else add_text(" ");
         end
         default: add_text(" ");
      endcase
   endtask

   // Receiver: random stall bursts, plus one long hold while the sender keeps
   // offering beats so that the result buffer fills and req_ready drops.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
         long_hold_done <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!long_hold_done && sent > 300) begin
         rsp_ready <= 1'b0;
         hold_left <= 200;
         long_hold_done <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         hold_left <= $urandom_range(0, 7);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         cycles <= 0;
      end else begin
         cycles <= cycles + 1;
         if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     pending_tokens);
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      int gap;
      sent = 0;
      quiet = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_in_char = 8'h00;
      req_in_end = 1'b0;

      // The longest keyword is built from two shorter ones.
      keywords[20] = {keywords[19], "_", keywords[14]};

      // Directed text: keywords, operators, escapes, the empty string, a
      // number ending in a minus at end of input, errors and an early NUL.
      add_text({"if ", keywords[20], "=>3-4 \"a\\nb\"\"\"([{}])"});
      add_end();
      add_text("7-");
      add_end();
      add_text("\"ab");
      add_end();
      add_text("x@y");
      add_end();
      add_byte({1'b0, 8'h00});
      add_text("q");
      add_end();
      add_byte({1'b0, 8'hff});
      add_end();
      add_end();

      while (source.size() < RANDOM_BYTES) begin
         add_random_token();
         if ($urandom_range(0, 40) == 0) add_end();
      end
      add_text(" ");
      add_end();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (source[i]) begin
         if (i > source.size() - 150) quiet = 1'b1;
         if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 8);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_in_end <= source[i][8];
         req_in_char <= source[i][7:0];
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         sent++;
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending_tokens != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d source beats, including end marks; checked %0d token beats.",
               sent, token_beats);
      if (fail_count == 0 && pending_tokens == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/kwt_pkg.sv
hdl/kwt_lexer.sv
hdl/kwt_outbuf.sv
hdl/keyword_tokenizer.sv
sim/kwt_checker.sv
sim/tb_keyword_tokenizer.sv
